[sv/fba_pkg.sv]
// Shared constants and types for the frame bitmap allocator.
package fba_pkg;

   localparam int MAP_BYTES_DEF   = 4096;
   localparam int FRAMES_PER_BYTE = 8;
   localparam int REG_W           = 13;
   localparam int ADDR_W          = 32;
   localparam int FRAME_SHIFT     = 12;
   localparam int GROUP_SHIFT     = 15;
   localparam int GROUP_IDX_W     = ADDR_W - GROUP_SHIFT;
   localparam int CSR_IDX_W       = 1;

   localparam logic [REG_W-1:0] GROUP_COUNT_RST = 13'd4096;
   localparam logic [REG_W-1:0] RSV_GROUPS_RST  = 13'd0;
   localparam logic [FRAMES_PER_BYTE-1:0] BYTE_FULL = 8'hff;

   typedef enum logic [1:0] {
      KIND_MARK_USED = 2'd0,
      KIND_MARK_FREE = 2'd1,
      KIND_FIND_FREE = 2'd2,
      KIND_INIT      = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RSV_GROUPS  = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_FIND,
      ST_SWEEP
   } fba_state_type;

endpackage

[sv/fba_map_ram.sv]
// Frame bitmap storage: one write port, one registered read port.
module fba_map_ram #(
   parameter int DEPTH = fba_pkg::MAP_BYTES_DEF,
   parameter int AW    = 12
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic [fba_pkg::FRAMES_PER_BYTE-1:0]  wr_data,
   input  logic [AW-1:0]                        rd_addr,
   output logic [fba_pkg::FRAMES_PER_BYTE-1:0]  rd_data
);

   logic [fba_pkg::FRAMES_PER_BYTE-1:0] mem [DEPTH];
   logic [fba_pkg::FRAMES_PER_BYTE-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fba_ctrl.sv]
// Sequencer for mark, find-first-free and initialize sweeps over the bitmap.
module fba_ctrl #(
   parameter int MAP_BYTES = fba_pkg::MAP_BYTES_DEF,
   parameter int IDX_W     = 12,
   parameter int CNT_W     = 13
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           kind,
   input  logic [fba_pkg::ADDR_W-1:0]           address,
   input  logic [CNT_W-1:0]                     act_bytes,
   input  logic [CNT_W-1:0]                     rsv_bytes,
   output logic                                 mem_wr_en,
   output logic [IDX_W-1:0]                     mem_wr_addr,
   output logic [fba_pkg::FRAMES_PER_BYTE-1:0]  mem_wr_data,
   output logic [IDX_W-1:0]                     mem_rd_addr,
   input  logic [fba_pkg::FRAMES_PER_BYTE-1:0]  mem_rd_data,
   output logic                                 rsp_strobe,
   output logic [fba_pkg::ADDR_W-1:0]           rsp_found_address,
   output logic                                 rsp_none_free,
   output logic                                 rsp_out_of_range
);

   localparam int CMP_W = (CNT_W > fba_pkg::GROUP_IDX_W) ? CNT_W : fba_pkg::GROUP_IDX_W;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAP_BYTES - 1);

   fba_pkg::fba_state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              set_ff, set_in;
   logic [2:0]        bit_ff, bit_in;
   logic [CNT_W-1:0]  rsv_ff, rsv_in;
   logic              init_rsp_ff, init_rsp_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [fba_pkg::ADDR_W-1:0]  found_ff, found_in;
   logic                        none_ff, none_in;
   logic                        oor_ff, oor_in;

   logic [fba_pkg::GROUP_IDX_W-1:0]      req_idx;
   logic                                 req_oor;
   logic                                 is_mark;
   logic                                 hit;
   logic                                 more;
   logic                                 last;
   logic [2:0]                           zero_pos;
   logic [fba_pkg::FRAMES_PER_BYTE-1:0]  bit_mask;

   assign req_idx = address[fba_pkg::ADDR_W-1:fba_pkg::GROUP_SHIFT];
   assign req_oor = CMP_W'(req_idx) >= CMP_W'(act_bytes);
   assign is_mark = (kind == fba_pkg::KIND_MARK_USED) || (kind == fba_pkg::KIND_MARK_FREE);
   assign hit     = chk_vld_ff && (mem_rd_data != fba_pkg::BYTE_FULL);
   assign more    = cnt_ff < act_bytes;
   assign last    = cnt_ff == LAST_IDX;
   assign bit_mask = fba_pkg::FRAMES_PER_BYTE'(1) << bit_ff;

   always_comb begin
      zero_pos = '0;
      for (int j = fba_pkg::FRAMES_PER_BYTE - 1; j >= 0; j--) begin
         if (!mem_rd_data[j]) begin
            zero_pos = 3'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  fba_pkg::KIND_MARK_USED, fba_pkg::KIND_MARK_FREE: begin
                     if (!req_oor) begin
                        state_in = fba_pkg::ST_MARK;
                     end
                  end
                  fba_pkg::KIND_FIND_FREE: state_in = fba_pkg::ST_FIND;
                  default:                 state_in = fba_pkg::ST_SWEEP;
               endcase
            end
         end
         fba_pkg::ST_MARK: state_in = fba_pkg::ST_IDLE;
         fba_pkg::ST_FIND: begin
            if (hit || !more) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end
         fba_pkg::ST_SWEEP: begin
            if (last) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end
         default: state_in = fba_pkg::ST_IDLE;
      endcase
   end

   // memory port and handshake outputs
   always_comb begin
      busy        = state_ff != fba_pkg::ST_IDLE;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cnt_ff[IDX_W-1:0];
      mem_wr_data = '0;
      mem_rd_addr = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         fba_pkg::ST_IDLE: mem_rd_addr = req_idx[IDX_W-1:0];
         fba_pkg::ST_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = chk_idx_ff;
            mem_wr_data = set_ff ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);
         end
         fba_pkg::ST_FIND: ;
         fba_pkg::ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (cnt_ff < rsv_ff) ? fba_pkg::BYTE_FULL : '0;
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      cnt_in        = cnt_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      set_in        = set_ff;
      bit_in        = bit_ff;
      rsv_in        = rsv_ff;
      init_rsp_in   = init_rsp_ff;
      rsp_strobe_in = 1'b0;
      found_in      = found_ff;
      none_in       = none_ff;
      oor_in        = oor_ff;
      case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in      = '0;
               chk_vld_in  = 1'b0;
               chk_idx_in  = req_idx[IDX_W-1:0];
               set_in      = kind == fba_pkg::KIND_MARK_USED;
               bit_in      = address[fba_pkg::GROUP_SHIFT-1:fba_pkg::FRAME_SHIFT];
               rsv_in      = rsv_bytes;
               init_rsp_in = 1'b1;
               if (is_mark && req_oor) begin
                  rsp_strobe_in = 1'b1;
                  found_in      = '0;
                  none_in       = 1'b0;
                  oor_in        = 1'b1;
               end
            end
         end
         fba_pkg::ST_MARK: begin
            rsp_strobe_in = 1'b1;
            found_in      = '0;
            none_in       = 1'b0;
            oor_in        = 1'b0;
         end
         fba_pkg::ST_FIND: begin
            if (hit) begin
               rsp_strobe_in = 1'b1;
               found_in      = (fba_pkg::ADDR_W'(chk_idx_ff) << fba_pkg::GROUP_SHIFT)
                             | (fba_pkg::ADDR_W'(zero_pos) << fba_pkg::FRAME_SHIFT);
               none_in       = 1'b0;
               oor_in        = 1'b0;
            end else if (more) begin
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + CNT_W'(1);
            end else begin
               rsp_strobe_in = 1'b1;
               found_in      = '0;
               none_in       = 1'b1;
               oor_in        = 1'b0;
            end
         end
         fba_pkg::ST_SWEEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (last) begin
               cnt_in        = '0;
               init_rsp_in   = 1'b0;
               rsp_strobe_in = init_rsp_ff;
               found_in      = '0;
               none_in       = 1'b0;
               oor_in        = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fba_pkg::ST_SWEEP;
         cnt_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         rsv_ff        <= '0;
         init_rsp_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         rsv_ff        <= rsv_in;
         init_rsp_ff   <= init_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      set_ff     <= set_in;
      bit_ff     <= bit_in;
      found_ff   <= found_in;
      none_ff    <= none_in;
      oor_ff     <= oor_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_found_address = found_ff;
   assign rsp_none_free     = none_ff;
   assign rsp_out_of_range  = oor_ff;

endmodule

[sv/frame_bitmap_allocator.sv]
// Top level of the first-fit page frame bitmap allocator.
// One bit per 4 KiB frame, eight frames per map byte, kept in a single-port-write RAM.
// Request channel: an item (req_kind, req_address) is taken when start is high and
// busy is low. Kinds: mark used, mark free, find first free, initialize.
// Result channel: rsp_strobe is high for one cycle with rsp_found_address,
// rsp_none_free and rsp_out_of_range; the receiver cannot stall it.
// Per item, shaped by the single RAM read port and its registered read:
//   mark in range: byte read at accept, rewritten in ST_MARK; busy only during ST_MARK.
//   mark out of range: result in the next cycle, map untouched, no busy time.
//   find: scans active bytes from byte 0 to the first with a free frame, or to the end;
//         one map byte is read per cycle.
//   initialize: every byte is rewritten, one per cycle.
// Reset: the registers return to their defaults and a clearing pass writes zero to all
// MAP_BYTES entries, one per cycle, with busy high and no result. Register writes on
// the csr_ port are taken at any time but must only happen while the block is idle.
module frame_bitmap_allocator #(
   parameter int MAP_BYTES = fba_pkg::MAP_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [fba_pkg::ADDR_W-1:0]        req_address,
   output logic                              rsp_strobe,
   output logic [fba_pkg::ADDR_W-1:0]        rsp_found_address,
   output logic                              rsp_none_free,
   output logic                              rsp_out_of_range,
   input  logic                              csr_write,
   input  logic [fba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fba_pkg::REG_W-1:0]         csr_wdata
);

   localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_W = $clog2(MAP_BYTES + 1);
   localparam int SAT_W = (CNT_W > fba_pkg::REG_W) ? CNT_W : fba_pkg::REG_W;
   localparam logic [SAT_W-1:0] MAP_LIMIT = SAT_W'(MAP_BYTES);

   logic [fba_pkg::REG_W-1:0] group_count_ff;
   logic [fba_pkg::REG_W-1:0] rsv_groups_ff;

   logic [SAT_W-1:0] act_wide;
   logic [SAT_W-1:0] rsv_wide;
   logic [CNT_W-1:0] act_bytes;
   logic [CNT_W-1:0] rsv_bytes;

   logic                                 mem_wr_en;
   logic [IDX_W-1:0]                     mem_wr_addr;
   logic [fba_pkg::FRAMES_PER_BYTE-1:0]  mem_wr_data;
   logic [IDX_W-1:0]                     mem_rd_addr;
   logic [fba_pkg::FRAMES_PER_BYTE-1:0]  mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff <= fba_pkg::GROUP_COUNT_RST;
         rsv_groups_ff  <= fba_pkg::RSV_GROUPS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            fba_pkg::CSR_GROUP_COUNT: group_count_ff <= csr_wdata;
            fba_pkg::CSR_RSV_GROUPS:  rsv_groups_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      act_wide = SAT_W'(group_count_ff);
      if (act_wide > MAP_LIMIT) begin
         act_wide = MAP_LIMIT;
      end
      rsv_wide = SAT_W'(rsv_groups_ff);
      if (rsv_wide > act_wide) begin
         rsv_wide = act_wide;
      end
   end

   assign act_bytes = act_wide[CNT_W-1:0];
   assign rsv_bytes = rsv_wide[CNT_W-1:0];

   fba_ctrl #(
      .MAP_BYTES (MAP_BYTES),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .kind              (req_kind),
      .address           (req_address),
      .act_bytes         (act_bytes),
      .rsv_bytes         (rsv_bytes),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_found_address (rsp_found_address),
      .rsp_none_free     (rsp_none_free),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   fba_map_ram #(
      .DEPTH (MAP_BYTES),
      .AW    (IDX_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[sim/fba_reply_check.sv]
// Reply checker for the frame bitmap allocator: tracks the map and compares every reply.
`timescale 1ns / 100ps

module fba_reply_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [fba_pkg::ADDR_W-1:0]     req_address,
   input  logic                           rsp_strobe,
   input  logic [fba_pkg::ADDR_W-1:0]     rsp_found_address,
   input  logic                           rsp_none_free,
   input  logic                           rsp_out_of_range,
   input  logic                           csr_write,
   input  logic [fba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fba_pkg::REG_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             owed_count
);

   typedef struct packed {
      logic [fba_pkg::ADDR_W-1:0] found_address;
      logic                       none_free;
      logic                       out_of_range;
   } reply_type;

   logic [fba_pkg::FRAMES_PER_BYTE-1:0] frame_map [fba_pkg::MAP_BYTES_DEF];
   logic [fba_pkg::REG_W-1:0]           group_count_q;
   logic [fba_pkg::REG_W-1:0]           reserved_q;
   reply_type                           pending_replies [$];

   function automatic reply_type serve_request(fba_pkg::kind_type kind,
                                               logic [fba_pkg::ADDR_W-1:0] addr);
      reply_type        r;
      int unsigned      act;
      int unsigned      lim;
      int unsigned      i;
      int unsigned      j;
      logic [16:0]      grp;
      logic [2:0]       slot;
      bit               hit;
      r = '0;
      act = (group_count_q > fba_pkg::MAP_BYTES_DEF) ? fba_pkg::MAP_BYTES_DEF : group_count_q;
      case (kind)
         fba_pkg::KIND_MARK_USED, fba_pkg::KIND_MARK_FREE: begin
            grp = addr[fba_pkg::ADDR_W-1:fba_pkg::GROUP_SHIFT];
            slot = addr[fba_pkg::GROUP_SHIFT-1:fba_pkg::FRAME_SHIFT];
            if (grp >= act) begin
               r.out_of_range = 1'b1;
            end else begin
               frame_map[grp[11:0]][slot] = (kind == fba_pkg::KIND_MARK_USED);
            end
         end
         fba_pkg::KIND_FIND_FREE: begin
            hit = 1'b0;
            for (i = 0; i < act && !hit; i++) begin
               for (j = 0; j < fba_pkg::FRAMES_PER_BYTE && !hit; j++) begin
                  if (!frame_map[12'(i)][3'(j)]) begin
                     hit = 1'b1;
                     r.found_address = (32'(i) << fba_pkg::GROUP_SHIFT)
                                     | (32'(j) << fba_pkg::FRAME_SHIFT);
                  end
               end
            end
            r.none_free = !hit;
         end
         default: begin
            lim = (reserved_q > act) ? act : reserved_q;
            for (i = 0; i < fba_pkg::MAP_BYTES_DEF; i++) begin
               frame_map[12'(i)] = (i < lim) ? fba_pkg::BYTE_FULL : '0;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         for (int k = 0; k < fba_pkg::MAP_BYTES_DEF; k++) begin
            frame_map[12'(k)] = '0;
         end
         group_count_q = fba_pkg::GROUP_COUNT_RST;
         reserved_q = fba_pkg::RSV_GROUPS_RST;
         pending_replies.delete();
      end else begin
         if (rsp_strobe) begin
            got = '{rsp_found_address, rsp_none_free, rsp_out_of_range};
            if (pending_replies.size() == 0) begin
               $display("%0t unexpected reply: found=%h none=%0b oor=%0b", $time,
                        got.found_address, got.none_free, got.out_of_range);
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (got.found_address !== want.found_address ||
                   got.none_free !== want.none_free ||
                   got.out_of_range !== want.out_of_range) begin
                  $display("%0t reply mismatch: expected found=%h none=%0b oor=%0b",
                           $time, want.found_address, want.none_free, want.out_of_range);
                  $display("%0t                 actual   found=%h none=%0b oor=%0b",
                           $time, got.found_address, got.none_free, got.out_of_range);
                  fail_count++;
               end
            end
         end
         if (csr_write) begin
            if (csr_index == fba_pkg::CSR_GROUP_COUNT) begin
               group_count_q = csr_wdata;
            end else if (csr_index == fba_pkg::CSR_RSV_GROUPS) begin
               reserved_q = csr_wdata;
            end
         end
         if (start && !busy) begin
            pending_replies.push_back(serve_request(fba_pkg::kind_type'(req_kind),
                                                    req_address));
         end
      end
      owed_count <= pending_replies.size();
   end

   initial begin
      fail_count = 0;
      owed_count = 0;
   end

endmodule

[sim/testbench.sv]
// Top of the frame bitmap allocator testbench: clock, reset, requests and the verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 8_000_000;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [1:0]                     req_kind;
   logic [fba_pkg::ADDR_W-1:0]     req_address;
   logic                           rsp_strobe;
   logic [fba_pkg::ADDR_W-1:0]     rsp_found_address;
   logic                           rsp_none_free;
   logic                           rsp_out_of_range;
   logic                           csr_write;
   logic [fba_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fba_pkg::REG_W-1:0]      csr_wdata;

   int                    fail_count;
   int                    owed_count;
   int unsigned           idle_pct;
   int unsigned           act_set;
   int unsigned           cycle_count;

   frame_bitmap_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_found_address (rsp_found_address),
      .rsp_none_free     (rsp_none_free),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   fba_reply_check i_reply_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_found_address (rsp_found_address),
      .rsp_none_free     (rsp_none_free),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .owed_count        (owed_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // busy only moves at rising edges, so its value at a falling edge holds for the next one
   task automatic send_item(input fba_pkg::kind_type kind,
                            input logic [fba_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      while (busy) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_address <= addr;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (owed_count != 0 || busy) @(negedge clock);
   endtask

   task automatic write_regs(input logic [fba_pkg::REG_W-1:0] groups,
                             input logic [fba_pkg::REG_W-1:0] rsv);
      csr_write <= 1'b1;
      csr_index <= fba_pkg::CSR_GROUP_COUNT;
      csr_wdata <= groups;
      @(negedge clock);
      csr_index <= fba_pkg::CSR_RSV_GROUPS;
      csr_wdata <= rsv;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      act_set = (groups > fba_pkg::MAP_BYTES_DEF) ? fba_pkg::MAP_BYTES_DEF : groups;
   endtask

   // mostly in-range or just past the active bytes, sometimes fully random
   function automatic logic [fba_pkg::ADDR_W-1:0] pick_address();
      logic [16:0] grp;
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         return $urandom;
      end
      if (act_set > 12) begin
         grp = (r == 2) ? 17'($urandom_range(act_set - 2, act_set))
                        : 17'($urandom_range(0, 7));
      end else begin
         grp = 17'($urandom_range(0, act_set));
      end
      return {grp, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095))};
   endfunction

   task automatic random_segment(input int unsigned n);
      int unsigned r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(fba_pkg::KIND_INIT, $urandom);
         end else if (r < 34) begin
            send_item(fba_pkg::KIND_FIND_FREE, $urandom);
         end else if (r < 72) begin
            send_item(fba_pkg::KIND_MARK_USED, pick_address());
         end else begin
            send_item(fba_pkg::KIND_MARK_FREE, pick_address());
         end
      end
   endtask

   initial begin
      logic [fba_pkg::REG_W-1:0] groups;
      logic [fba_pkg::REG_W-1:0] rsv;
      int unsigned               idle_plan [3];
      reset = 1'b1;
      start = 1'b0;
      req_kind = fba_pkg::KIND_MARK_USED;
      req_address = '0;
      csr_write = 1'b0;
      csr_index = fba_pkg::CSR_GROUP_COUNT;
      csr_wdata = '0;
      cycle_count = 0;
      idle_pct = 0;
      act_set = fba_pkg::MAP_BYTES_DEF;
      idle_plan = '{11, 54, 0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      drain();

      // default registers: full map of 4096 bytes
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      send_item(fba_pkg::KIND_MARK_USED, 32'h0000_0000);
      send_item(fba_pkg::KIND_FIND_FREE, 32'hffff_ffff);
      send_item(fba_pkg::KIND_MARK_USED, 32'hffff_ffff);
      send_item(fba_pkg::KIND_MARK_USED, 32'h07ff_ffff);
      send_item(fba_pkg::KIND_MARK_FREE, 32'h0800_0000);
      send_item(fba_pkg::KIND_MARK_FREE, 32'h0000_0abc);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      send_item(fba_pkg::KIND_INIT, 32'h0);
      // no active bytes
      drain();
      write_regs(13'd0, 13'h1fff);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      send_item(fba_pkg::KIND_MARK_USED, 32'h0000_0000);
      send_item(fba_pkg::KIND_INIT, 32'h0);
      // both registers at their largest: every byte reserved
      drain();
      write_regs(13'h1fff, 13'h1fff);
      send_item(fba_pkg::KIND_INIT, 32'h0);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      send_item(fba_pkg::KIND_MARK_FREE, 32'h07ff_f000);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      // reserved count clipped to the active count
      drain();
      write_regs(13'd2, 13'd5);
      send_item(fba_pkg::KIND_INIT, 32'h0);
      send_item(fba_pkg::KIND_MARK_FREE, 32'h0000_f000);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);
      send_item(fba_pkg::KIND_MARK_USED, 32'h0000_7fff);
      send_item(fba_pkg::KIND_MARK_USED, 32'h0001_0000);
      send_item(fba_pkg::KIND_FIND_FREE, 32'h0);

      for (int mode = 0; mode < 3; mode++) begin
         idle_pct = idle_plan[mode];
         for (int seg = 0; seg < 3; seg++) begin
            drain();
            case ($urandom_range(0, 9))
               0: groups = '0;
               1: groups = $urandom_range(0, 1) ? 13'h1fff : 13'd4096;
               default: groups = 13'($urandom_range(1, 12));
            endcase
            if (groups > 12) begin
               rsv = 13'($urandom_range(0, 3));
            end else if ($urandom_range(0, 7) == 0) begin
               rsv = 13'h1fff;
            end else begin
               rsv = 13'($urandom_range(0, 32'(groups) + 2));
            end
            write_regs(groups, rsv);
            random_segment(61);
         end
      end

      drain();
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
sv/fba_pkg.sv
sv/fba_map_ram.sv
sv/fba_ctrl.sv
sv/frame_bitmap_allocator.sv
sim/fba_reply_check.sv
sim/testbench.sv
